/* rtl/core/rkc_pkg.sv */
// Shared types, constants and state encoding for the RGB 5x5 convolution unit.
`default_nettype none

package rkc_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_KERNEL_SIZE = 5;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int ROW_SLOTS  = 4;
    localparam int WIN        = 5;
    localparam int WIN_IDX_W  = 3;
    localparam int ROW_W      = 12;
    localparam int HEIGHT_W   = 13;
    localparam int IMG_W_W    = 11;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int TAP_IDX_W  = 5;
    localparam int ACC_W      = 22;
    localparam int TOT_W      = 14;
    localparam int NUM_W      = 24;
    localparam int DEN_W      = 16;
    localparam int MIN_DIM    = 5;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

    localparam logic [63:0]         KERNEL_1_RESET = 64'h0000_0001_0000_0000;
    localparam logic [IMG_W_W-1:0]  WIDTH_RESET    = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 13'd480;

    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_last;
    } pix_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_NORM,
        ST_DIV,
        ST_OUT
    } rkc_state_t;

endpackage

`default_nettype wire

/* rtl/core/rgb_kernel_convolution_5x5_unit.sv */
// Top level of the streaming RGB 5x5 normalized convolution unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | in_data  (mode, red/green/blue)
//  out     | output    | out_valid / out_ready| out_data (red/green/blue, last)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One item at a time. A pixel with no result only passes the read step, a
// border pixel is passed through from the row store, and an interior pixel
// takes KERNEL_SIZE^2 taps, one tap per cycle on a shared multiply-accumulate,
// then the bit-serial divider when the kernel sum is nonzero. A flush that
// drains a pixel passes the read and output steps; any other flush is dropped.
// Reset clears counters, handshake state and loads the identity kernel and
// 640x480; the row store needs no clear. Output is held in a register, so the
// next input is taken while a result waits; the FSM stalls only in its final
// step if that register is still full.
`default_nettype none

module rgb_kernel_convolution_5x5_unit #(
    parameter int MAX_WIDTH   = rkc_pkg::DEF_MAX_WIDTH,
    parameter int KERNEL_SIZE = rkc_pkg::DEF_KERNEL_SIZE
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire rkc_pkg::pix_in_t                 in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output rkc_pkg::pix_out_t                     out_data,
    input  wire logic                             cfg_write,
    input  wire logic [rkc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rkc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import rkc_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HALF   = KERNEL_SIZE / 2;
    localparam int ORG    = 2 - HALF;
    localparam int TAPS   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int WORD_W = ROW_SLOTS * PIX_W;

    // configuration
    logic [63:0]         kw0_reg, kw1_reg, kw2_reg;
    logic [7:0]          kw3_reg;
    logic [IMG_W_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [199:0]        coef_flat;

    // stream position
    logic [CW-1:0]       in_col_reg, in_col_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]       out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    // per-item context captured at the input transfer
    logic                flush_reg, emit_reg, last_reg, inner_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [CW-1:0]       ix_reg;
    logic [1:0]          slot_reg;
    logic [1:0]          oslot_reg;

    rkc_state_t          state_reg, state_next;

    logic [PIX_W-1:0]    win_reg [WIN][WIN];
    logic [TAP_IDX_W-1:0] k_reg;
    logic [WIN_IDX_W-1:0] kr_reg, kc_reg;
    logic signed [ACC_W-1:0] sum_reg [3];
    logic signed [TOT_W-1:0] tot_reg;
    logic [PIX_W-1:0]    res_reg;

    logic                out_valid_reg;
    pix_out_t            out_data_reg;

    // ram
    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata, rd_a, rd_b;
    logic [CW-1:0]       ram_ra_b;

    // accept-time decode
    logic                in_xfer, is_flush, in_start, out_zero, data_ready, emit_now;
    logic                last_now, inner_now;
    logic [CW-1:0]       ox_cur;
    logic [ROW_W-1:0]    oy_cur;
    logic                out_free, mac_last, div_start;

    logic [PIX_W-1:0]    tap;
    logic signed [7:0]   coef;
    logic signed [16:0]  prod [3];
    logic                div_done [3];
    logic [CH_W-1:0]     div_res [3];
    logic signed [NUM_W-1:0] div_num [3];
    logic signed [DEN_W-1:0] div_den;

    // frame size saturated into the supported range
    always_comb
    begin
        if (width_reg < IMG_W_W'(MIN_DIM))
        begin
            eff_w = WW'(MIN_DIM);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end
        if (height_reg < HEIGHT_W'(MIN_DIM))
        begin
            eff_h = HEIGHT_W'(MIN_DIM);
        end
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
        begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign coef_flat = {kw3_reg, kw2_reg, kw1_reg, kw0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw0_reg    <= '0;
            kw1_reg    <= KERNEL_1_RESET;
            kw2_reg    <= '0;
            kw3_reg    <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KERNEL_0: kw0_reg    <= cfg_data;
                REG_KERNEL_1: kw1_reg    <= cfg_data;
                REG_KERNEL_2: kw2_reg    <= cfg_data;
                REG_KERNEL_3: kw3_reg    <= cfg_data[7:0];
                REG_WIDTH:    width_reg  <= cfg_data[IMG_W_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_data[HEIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Input transfer decode. A data pixel at the top-left of a frame restarts
    // the output position, dropping anything left undrained.
    always_comb
    begin
        in_xfer    = in_valid && in_ready;
        is_flush   = (in_data.mode == MODE_FLUSH);
        in_start   = (in_col_reg == '0) && (in_row_reg == '0);
        out_zero   = (out_col_reg == '0) && (out_row_reg == '0);
        ox_cur     = (!is_flush && in_start) ? '0 : out_col_reg;
        oy_cur     = (!is_flush && in_start) ? '0 : out_row_reg;
        data_ready = (in_row_reg > ROW_W'(2)) ||
                     ((in_row_reg == ROW_W'(2)) && (in_col_reg >= CW'(2)));
        emit_now   = is_flush ? (in_start && !out_zero) : data_ready;
        last_now   = (WW'(ox_cur) == eff_w - WW'(1)) &&
                     (HEIGHT_W'(oy_cur) == eff_h - HEIGHT_W'(1));
        inner_now  = !is_flush && (ox_cur >= CW'(2)) && (oy_cur >= ROW_W'(2)) &&
                     ((WW + 1)'(ox_cur) + (WW + 1)'(2) < (WW + 1)'(eff_w)) &&
                     ((HEIGHT_W + 1)'(oy_cur) + (HEIGHT_W + 1)'(2) <
                      (HEIGHT_W + 1)'(eff_h));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (!is_flush)
        begin
            out_col_next = ox_cur;
            out_row_next = oy_cur;
            if (WW'(in_col_reg) + WW'(1) >= eff_w)
            begin
                in_col_next = '0;
                in_row_next = (HEIGHT_W'(in_row_reg) + HEIGHT_W'(1) >= eff_h) ?
                              '0 : in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (emit_now)
        begin
            if (WW'(ox_cur) + WW'(1) >= eff_w)
            begin
                out_col_next = '0;
                out_row_next = (HEIGHT_W'(oy_cur) + HEIGHT_W'(1) >= eff_h) ?
                               '0 : oy_cur + ROW_W'(1);
            end
            else
            begin
                out_col_next = ox_cur + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (in_xfer)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            flush_reg <= is_flush;
            emit_reg  <= emit_now;
            last_reg  <= last_now;
            inner_reg <= inner_now;
            pix_reg   <= {in_data.blue_in, in_data.green_in, in_data.red_in};
            ix_reg    <= in_col_reg;
            slot_reg  <= in_row_reg[1:0];
            oslot_reg <= oy_cur[1:0];
        end
    end

    // Row store: one word per column holds that column of the last four rows.
    // Port A fetches the column for the window and is written back with the
    // new pixel in its row slot; port B fetches a pass-through pixel.
    assign ram_ra_b = ox_cur;

    always_comb
    begin
        ram_wdata = rd_a;
        ram_wdata[slot_reg*PIX_W +: PIX_W] = pix_reg;
    end

    rkc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ix_reg),
        .wdata   (ram_wdata),
        .raddr_a (in_col_reg),
        .rdata_a (rd_a),
        .raddr_b (ram_ra_b),
        .rdata_b (rd_b)
    );

    // Window: column 4 takes rows y-4..y-1 from the store and the new pixel.
    // The row slot wraps modulo four.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ && !flush_reg)
        begin
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c + 1];
                end
                if (r < WIN - 1)
                begin
                    win_reg[r][WIN-1] <= rd_a[2'(slot_reg + 2'(r))*PIX_W +: PIX_W];
                end
                else
                begin
                    win_reg[r][WIN-1] <= pix_reg;
                end
            end
        end
    end

    // Multiply-accumulate, one tap per cycle for all three channels.
    always_comb
    begin
        tap  = win_reg[WIN_IDX_W'(ORG) + kr_reg][WIN_IDX_W'(ORG) + kc_reg];
        coef = $signed(coef_flat[k_reg*8 +: 8]);
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = $signed({1'b0, tap[ch*CH_W +: CH_W]}) * coef;
        end
        mac_last = (k_reg == TAP_IDX_W'(TAPS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            k_reg   <= '0;
            kr_reg  <= '0;
            kc_reg  <= '0;
            tot_reg <= '0;
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= '0;
            end
        end
        else if (state_reg == ST_MAC)
        begin
            k_reg   <= k_reg + TAP_IDX_W'(1);
            tot_reg <= tot_reg + TOT_W'(coef);
            if (kc_reg == WIN_IDX_W'(KERNEL_SIZE - 1))
            begin
                kc_reg <= '0;
                kr_reg <= kr_reg + WIN_IDX_W'(1);
            end
            else
            begin
                kc_reg <= kc_reg + WIN_IDX_W'(1);
            end
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= sum_reg[ch] + ACC_W'(prod[ch]);
            end
        end
    end

    // Normalization: q = floor((2*sum + total) / (2*total)).
    assign div_den = {tot_reg[TOT_W-1], tot_reg, 1'b0};

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_div
        assign div_num[ch] = {sum_reg[ch][ACC_W-1], sum_reg[ch], 1'b0} +
                             {{(NUM_W - TOT_W){tot_reg[TOT_W-1]}}, tot_reg};

        rkc_div u_div (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (div_start),
            .num    (div_num[ch]),
            .den    (div_den),
            .done   (div_done[ch]),
            .result (div_res[ch])
        );
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_READ:
            begin
                res_reg <= rd_b[oslot_reg*PIX_W +: PIX_W];
            end
            ST_NORM:
            begin
                // zero kernel sum: raw sum clamped
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (sum_reg[ch] < 0)
                    begin
                        res_reg[ch*CH_W +: CH_W] <= '0;
                    end
                    else if (sum_reg[ch] > ACC_W'(255))
                    begin
                        res_reg[ch*CH_W +: CH_W] <= 8'hFF;
                    end
                    else
                    begin
                        res_reg[ch*CH_W +: CH_W] <= sum_reg[ch][CH_W-1:0];
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done[0])
                begin
                    res_reg <= {div_res[2], div_res[1], div_res[0]};
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = emit_now || !is_flush ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (!emit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (inner_reg)
                begin
                    state_next = ST_MAC;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MAC:
            begin
                if (mac_last)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                state_next = (tot_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done[0])
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        in_ready  = (state_reg == ST_IDLE);
        ram_we    = (state_reg == ST_READ) && !flush_reg;
        div_start = (state_reg == ST_NORM) && (tot_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.red_out    <= res_reg[0*CH_W +: CH_W];
            out_data_reg.green_out  <= res_reg[1*CH_W +: CH_W];
            out_data_reg.blue_out   <= res_reg[2*CH_W +: CH_W];
            out_data_reg.frame_last <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/rkc_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none

module rkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* rtl/core/rkc_div.sv */
// Iterative floor divider with clamp to 0..255, one quotient bit per cycle.
`default_nettype none

module rkc_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [rkc_pkg::NUM_W-1:0]  num,
    input  wire logic signed [rkc_pkg::DEN_W-1:0]  den,
    output logic                                   done,
    output logic             [rkc_pkg::CH_W-1:0]   result
);

    import rkc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic [NUM_W-1:0]        quo_reg, quo_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DEN_W-1:0]        den_reg, den_next;

    logic signed [NUM_W-1:0] n_s;
    logic signed [DEN_W-1:0] d_s;
    logic [DEN_W-1:0]        rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        n_s       = (den < 0) ? -num : num;
        d_s       = (den < 0) ? -den : den;
        rem_sh    = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
        done      = 1'b0;
        if (start)
        begin
            // floor: negative numerators divide (|n| + d - 1) and are flagged negative
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            neg_next  = n_s[NUM_W-1];
            quo_next  = n_s[NUM_W-1] ? NUM_W'(-n_s + NUM_W'(d_s) - NUM_W'(1)) : n_s;
            den_next  = d_s;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= den_reg)
            begin
                rem_next = rem_sh - den_reg;
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    // negative quotient clamps to zero
    always_comb
    begin
        if (neg_reg)
        begin
            result = '0;
        end
        else if (quo_next > NUM_W'(255))
        begin
            result = 8'hFF;
        end
        else
        begin
            result = quo_next[CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire

/* verif/rgb_kernel_convolution_5x5_checker.sv */
// Checker for the RGB 5x5 convolution unit: predicts every result and compares it.
`timescale 1ns / 1ps

module rgb_kernel_convolution_5x5_checker
    import rkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  pix_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  pix_out_t              out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int ROW_LEN = DEF_MAX_WIDTH;

    logic [63:0]         kern_word [4];
    logic [IMG_W_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    line_mem [ROW_SLOTS*ROW_LEN];
    logic [PIX_W-1:0]    taps [WIN][WIN];
    int unsigned         in_x, in_y, out_x, out_y;
    pix_out_t            filtered_q [$];

    function automatic int tap_coef(int k);
        logic [7:0] b;
        b = 8'(kern_word[k >> 3] >> ((k & 7) * 8));
        return $signed(b);
    endfunction

    function automatic longint floor_quot(longint n, longint d);
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic logic [7:0] sat_byte(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [PIX_W-1:0] line_rd(int unsigned row, int unsigned col);
        if (col >= ROW_LEN)
            return '0;
        return line_mem[(row & 3) * ROW_LEN + col];
    endfunction

    function automatic logic [PIX_W-1:0] weighted_pixel();
        longint acc [3];
        longint ksum;
        int     c;
        logic [PIX_W-1:0] res;
        acc = '{0, 0, 0};
        ksum = 0;
        for (int r = 0; r < WIN; r++)
            for (int q = 0; q < WIN; q++)
            begin
                c = tap_coef(r * WIN + q);
                ksum += c;
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(taps[r][q][8*ch +: 8]) * c;
            end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (ksum != 0)
                acc[ch] = floor_quot(2 * acc[ch] + ksum, 2 * ksum);
            res[8*ch +: 8] = sat_byte(acc[ch]);
        end
        return res;
    endfunction

    // Raster position step with wrap at frame end.
    function automatic void next_pos(ref int unsigned x, ref int unsigned y,
                                     input int unsigned w, input int unsigned h);
        if (x + 1 >= w)
        begin
            x = 0;
            y = (y + 1 >= h) ? 0 : y + 1;
        end
        else
            x = x + 1;
    endfunction

    function automatic void push_result(bit use_taps, int unsigned w, int unsigned h);
        logic [PIX_W-1:0] p;
        pix_out_t o;
        if (use_taps && out_x >= 2 && out_x + 2 < w && out_y >= 2 && out_y + 2 < h)
            p = weighted_pixel();
        else
            p = line_rd(out_y, out_x);
        o.red_out    = p[7:0];
        o.green_out  = p[15:8];
        o.blue_out   = p[23:16];
        o.frame_last = (out_x == w - 1 && out_y == h - 1);
        filtered_q.push_back(o);
        next_pos(out_x, out_y, w, h);
    endfunction

    function automatic void take_pixel(pix_in_t d);
        int unsigned w, h;
        logic [PIX_W-1:0] pix;
        w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > ROW_LEN) ? ROW_LEN : width_reg;
        h = (height_reg < MIN_DIM) ? MIN_DIM
          : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        if (d.mode == MODE_FLUSH)
        begin
            // drain only between frames while outputs are still owed
            if ((in_x | in_y) == 0 && (out_x | out_y) != 0)
                push_result(1'b0, w, h);
            return;
        end
        pix = {d.blue_in, d.green_in, d.red_in};
        if (in_x == 0 && in_y == 0)
        begin
            out_x = 0;
            out_y = 0;
        end
        for (int r = 0; r < WIN; r++)
        begin
            for (int q = 0; q < WIN - 1; q++)
                taps[r][q] = taps[r][q+1];
            taps[r][WIN-1] = (r < WIN - 1) ? line_rd(in_y + r, in_x) : pix;
        end
        if (in_x < ROW_LEN)
            line_mem[(in_y & 3) * ROW_LEN + in_x] = pix;
        if (in_y > 2 || (in_y == 2 && in_x >= 2))
        begin
            next_pos(in_x, in_y, w, h);
            push_result(1'b1, w, h);
        end
        else
            next_pos(in_x, in_y, w, h);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            kern_word  = '{64'd0, KERNEL_1_RESET, 64'd0, 64'd0};
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (line_mem[i])
                line_mem[i] = '0;
            foreach (taps[r, q])
                taps[r][q] = '0;
            in_x = 0; in_y = 0; out_x = 0; out_y = 0;
            filtered_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
                case (cfg_index)
                    REG_KERNEL_0: kern_word[0] = cfg_data;
                    REG_KERNEL_1: kern_word[1] = cfg_data;
                    REG_KERNEL_2: kern_word[2] = cfg_data;
                    REG_KERNEL_3: kern_word[3] = {56'd0, cfg_data[7:0]};
                    REG_WIDTH:    width_reg    = cfg_data[IMG_W_W-1:0];
                    REG_HEIGHT:   height_reg   = cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            if (out_valid && out_ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: expected none, got %h",
                             $realtime, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (want !== out_data)
                    begin
                        $display({"%0t ERROR result: expected r=%h g=%h b=%h last=%b,",
                                  " got r=%h g=%h b=%h last=%b"},
                                 $realtime, want.red_out, want.green_out, want.blue_out,
                                 want.frame_last, out_data.red_out, out_data.green_out,
                                 out_data.blue_out, out_data.frame_last);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                take_pixel(in_data);
            pending <= filtered_q.size();
        end
    end

endmodule

/* verif/rgb_kernel_convolution_5x5_unit_tb.sv */
// Testbench top: drives frames, flushes and kernel setups into the convolution unit.
`timescale 1ns / 1ps

module rgb_kernel_convolution_5x5_unit_tb;
    import rkc_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    pix_out_t              out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    // Idle rates in percent per cycle, switched as the run progresses.
    int     send_idle_pct;
    int     recv_idle_pct;
    int     pixels_sent;
    longint cycles;
    // Long receiver hold-off, requested once by the stimulus.
    bit     hold_go;
    bit     hold_used;
    int     hold_left;

    rgb_kernel_convolution_5x5_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgb_kernel_convolution_5x5_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rgb_kernel_convolution_5x5_unit_tb: done, errors");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long stall so the output
    // register fills and the block has to hold off its input.
    initial
    begin
        hold_used = 0;
        hold_left = 0;
    end
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_used = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // One register write, with cfg_write dropped again afterwards; the block is idle whenever this runs.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item and hold it until the transfer happens.
    task automatic send(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: mode, red_in: r, green_in: g, blue_in: b};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
        send_idle_pct = (pixels_sent < 600) ? 6 : (pixels_sent < 1200) ? 46 : 0;
        recv_idle_pct = (pixels_sent < 600) ? 46 : (pixels_sent < 1200) ? 6 : 0;
    endtask

    // Sender pause: wait for every owed result, then let the block return to
    // idle before anything is reconfigured.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Full raster frame, then n_flush drain ticks. Style 1 favors 0 and 255.
    task automatic run_frame(int w, int h, int n_flush, int style);
        logic [7:0] c [3];
        for (int i = 0; i < w * h; i++)
        begin
            foreach (c[k])
                c[k] = (style == 1 && $urandom_range(0, 3) != 0)
                       ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
            send(1'b0, c[0], c[1], c[2]);
        end
        repeat (n_flush)
            send(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Random kernel: full-range bytes, small weights, or a zero-sum kernel.
    task automatic load_kernel(int style);
        logic [7:0] cf [25];
        int s;
        s = 0;
        foreach (cf[k])
        begin
            cf[k] = (style == 0) ? 8'($urandom) : 8'($signed($urandom_range(0, 8)) - 4);
            if (k < 24)
                s += $signed(cf[k]);
        end
        if (style == 2 && s >= -128 && s <= 127)
            cf[24] = 8'(-s);
        write_reg(REG_KERNEL_0, {cf[7], cf[6], cf[5], cf[4], cf[3], cf[2], cf[1], cf[0]});
        write_reg(REG_KERNEL_1, {cf[15], cf[14], cf[13], cf[12], cf[11], cf[10], cf[9], cf[8]});
        write_reg(REG_KERNEL_2, {cf[23], cf[22], cf[21], cf[20], cf[19], cf[18], cf[17], cf[16]});
        write_reg(REG_KERNEL_3, {56'($urandom), cf[24]});
    endtask

    initial
    begin
        int wr, hr, w, h;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_go     = 0;
        pixels_sent = 0;
        send_idle_pct = 6;
        recv_idle_pct = 46;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flush with nothing owed, then a 5x5 frame through the
        // identity kernel left by reset, extreme pixels, an extra flush.
        send(MODE_FLUSH, 8'hff, 8'hff, 8'hff);
        wait_idle();
        write_reg(REG_WIDTH, 64'd5);
        write_reg(REG_HEIGHT, 64'd5);
        run_frame(5, 5, 13, 1);
        wait_idle();
        // Saturating kernels: all +127 and all -128, sizes below the minimum.
        write_reg(REG_KERNEL_0, {8{8'h7f}});
        write_reg(REG_KERNEL_1, {8{8'h7f}});
        write_reg(REG_KERNEL_2, {8{8'h7f}});
        write_reg(REG_KERNEL_3, 64'h7f);
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd4);
        run_frame(5, 5, 12, 1);
        wait_idle();
        write_reg(REG_KERNEL_0, {8{8'h80}});
        write_reg(REG_KERNEL_1, {8{8'h80}});
        write_reg(REG_KERNEL_2, {8{8'h80}});
        write_reg(REG_KERNEL_3, 64'h80);
        run_frame(5, 5, 12, 1);
        wait_idle();

        // Random frames; most drained in full, some cut short so that the
        // next frame start drops the undrained outputs.
        while (pixels_sent < 1700)
        begin
            wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
            hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
            w  = clip(wr, 5, 1024);
            h  = clip(hr, 5, 4096);
            load_kernel($urandom_range(0, 2));
            write_reg(REG_WIDTH, {53'd0, 11'(wr)});
            write_reg(REG_HEIGHT, {51'd0, 13'(hr)});
            if (pixels_sent > 800 && !hold_go)
                hold_go = 1;
            if ($urandom_range(0, 5) == 0)
                run_frame(w, h, $urandom_range(0, 2 * w), $urandom_range(0, 1));
            run_frame(w, h, 2 * w + 2 + $urandom_range(0, 2), $urandom_range(0, 1));
            wait_idle();
        end
        repeat (100) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("rgb_kernel_convolution_5x5_unit_tb: done, clean");
        else
            $display("rgb_kernel_convolution_5x5_unit_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/rkc_pkg.sv
rtl/core/rkc_ram.sv
rtl/core/rkc_div.sv
rtl/core/rgb_kernel_convolution_5x5_unit.sv
verif/rgb_kernel_convolution_5x5_checker.sv
verif/rgb_kernel_convolution_5x5_unit_tb.sv
